>>> rtl/polygon_half_plane_clipper_assert.svh
// Assertion macros for the polygon half-plane clipper.
`ifndef POLYGON_HALF_PLANE_CLIPPER_ASSERT_SVH
`define POLYGON_HALF_PLANE_CLIPPER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PHC_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PHC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/phc_pkg.sv
// Shared types and constants for the polygon half-plane clipper.
`timescale 1ns / 1ps
package phc_pkg;

    localparam int COORD_W   = 32;
    localparam int DIST_W    = 64;
    localparam int TOL_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam int MDX_W     = COORD_W + 1;
    localparam int PROD_W    = MDX_W + 32;
    localparam int NUM_W     = MDX_W + DIST_W;
    localparam int QUO_W     = 42;
    localparam int SUM_W     = QUO_W + 2;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(281);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X     = 2'd0,
        CFG_NORMAL_Y     = 2'd1,
        CFG_PLANE_OFFSET = 2'd2,
        CFG_INSIDE_TOL   = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_D0,
        OP_D1,
        OP_D2,
        OP_XSET,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_DIV,
        OP_FIN,
        OP_STORE,
        OP_EMIT_START,
        OP_EMIT_CROSS,
        OP_EMIT_BARE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   edge_b;
        logic   coord_y;
        logic   end_mark;
    } dp_cmd_t;

    typedef struct packed {
        logic have_first;
        logic cur_last;
        logic prev_in;
        logic cur_in;
        logic first_in;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/phc_datapath.sv
// Datapath: vertex state, distance unit, crossing multiplier/divider, output register.
`timescale 1ns / 1ps
module phc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [phc_pkg::COORD_W-1:0]  in_x,
    input  logic signed [phc_pkg::COORD_W-1:0]  in_y,
    input  logic                                in_last,
    input  logic signed [phc_pkg::COORD_W-1:0]  normal_x,
    input  logic signed [phc_pkg::COORD_W-1:0]  normal_y,
    input  logic signed [phc_pkg::DIST_W-1:0]   plane_offset,
    input  logic        [phc_pkg::TOL_W-1:0]    inside_tolerance,
    input  phc_pkg::dp_cmd_t                    cmd,
    output phc_pkg::dp_stat_t                   stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [phc_pkg::COORD_W-1:0]  out_x,
    output logic signed [phc_pkg::COORD_W-1:0]  out_y,
    output logic                                out_has_vertex,
    output logic                                out_end
);
    import phc_pkg::*;

    logic signed [COORD_W-1:0] cur_x_reg, cur_y_reg, prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] first_x_reg, first_y_reg;
    logic signed [DIST_W-1:0]  cur_d_reg, prev_d_reg, first_d_reg;
    logic                      cur_last_reg;
    logic                      have_first_reg, have_first_next;

    logic signed [DIST_W-1:0]  pdist_reg;
    logic signed [DIST_W+1:0]  acc_reg;

    logic signed [COORD_W-1:0] s_reg;
    logic [MDX_W-1:0]          mdx_reg;
    logic [DIST_W-1:0]         mds_reg;
    logic [DIST_W-1:0]         den_reg;
    logic                      neg_reg;
    logic [PROD_W-1:0]         p_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [DIST_W-1:0]         rem_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic                      ovf_reg;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;

    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic                      out_has_reg, out_end_reg;

    logic signed [COORD_W-1:0] mul_a, mul_b;
    logic signed [DIST_W-1:0]  smul;
    logic [PROD_W-1:0]         umul;
    logic [31:0]               umul_b;
    logic signed [DIST_W+1:0]  dist_sum;
    logic signed [DIST_W-1:0]  dist_sat;
    logic [DIST_W-1:0]         tol_ext;

    logic signed [COORD_W-1:0] xs, xe;
    logic signed [DIST_W-1:0]  xds, xde;
    logic signed [MDX_W-1:0]   xdx;
    logic signed [DIST_W:0]    xdiff;

    logic [DIST_W:0]           div_try;
    logic                      div_ge;
    logic [SUM_W-1:0]          quo_ext;
    logic [SUM_W-1:0]          fin_sum;
    logic signed [COORD_W-1:0] fin_val;

    logic                      emit;
    logic signed [COORD_W-1:0] emit_x, emit_y;

    // Distance: one signed multiplier, x*nx then y*ny.
    assign mul_a = (cmd.op == OP_D1) ? cur_y_reg : cur_x_reg;
    assign mul_b = (cmd.op == OP_D1) ? normal_y : normal_x;
    assign smul  = DIST_W'(mul_a) * DIST_W'(mul_b);
    assign dist_sum = acc_reg + {{2{pdist_reg[DIST_W-1]}}, pdist_reg};

    always_comb
    begin
        if (dist_sum[DIST_W+1:DIST_W-1] == 3'b000 || dist_sum[DIST_W+1:DIST_W-1] == 3'b111)
        begin
            dist_sat = dist_sum[DIST_W-1:0];
        end
        else if (dist_sum[DIST_W+1])
        begin
            dist_sat = {1'b1, {(DIST_W-1){1'b0}}};
        end
        else
        begin
            dist_sat = {1'b0, {(DIST_W-1){1'b1}}};
        end
    end

    assign tol_ext = {{(DIST_W-TOL_W){1'b0}}, inside_tolerance};

    // Crossing setup operands.
    always_comb
    begin
        if (cmd.coord_y)
        begin
            xs = cmd.edge_b ? cur_y_reg : prev_y_reg;
            xe = cmd.edge_b ? first_y_reg : cur_y_reg;
        end
        else
        begin
            xs = cmd.edge_b ? cur_x_reg : prev_x_reg;
            xe = cmd.edge_b ? first_x_reg : cur_x_reg;
        end
        xds   = cmd.edge_b ? cur_d_reg : prev_d_reg;
        xde   = cmd.edge_b ? first_d_reg : cur_d_reg;
        xdx   = {xe[COORD_W-1], xe} - {xs[COORD_W-1], xs};
        xdiff = {xds[DIST_W-1], xds} - {xde[DIST_W-1], xde};
    end

    // Product |dx|*|ds| in two 32-bit halves of |ds|.
    assign umul_b = (cmd.op == OP_MUL1) ? mds_reg[DIST_W-1:32] : mds_reg[31:0];
    assign umul   = PROD_W'(mdx_reg) * PROD_W'(umul_b);

    // Restoring division, one quotient bit per cycle.
    assign div_try = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge  = div_try >= {1'b0, den_reg};

    assign quo_ext = {2'b00, quo_reg};
    assign fin_sum = {{(SUM_W-COORD_W){s_reg[COORD_W-1]}}, s_reg}
                   + (neg_reg ? (~quo_ext + SUM_W'(1)) : quo_ext);

    always_comb
    begin
        if (ovf_reg)
        begin
            fin_val = neg_reg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (!fin_sum[SUM_W-1] && (|fin_sum[SUM_W-2:COORD_W-1]))
        begin
            fin_val = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (fin_sum[SUM_W-1] && !(&fin_sum[SUM_W-2:COORD_W-1]))
        begin
            fin_val = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            fin_val = fin_sum[COORD_W-1:0];
        end
    end

    // Output selection.
    assign emit = (cmd.op == OP_EMIT_START) || (cmd.op == OP_EMIT_CROSS)
               || (cmd.op == OP_EMIT_BARE);

    always_comb
    begin
        unique case (cmd.op)
            OP_EMIT_START:
            begin
                emit_x = cmd.edge_b ? cur_x_reg : prev_x_reg;
                emit_y = cmd.edge_b ? cur_y_reg : prev_y_reg;
            end
            OP_EMIT_CROSS:
            begin
                emit_x = cx_reg;
                emit_y = cy_reg;
            end
            default:
            begin
                emit_x = '0;
                emit_y = '0;
            end
        endcase
    end

    // Control state.
    always_comb
    begin
        have_first_next = have_first_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        if (cmd.op == OP_STORE)
        begin
            have_first_next = !cur_last_reg;
        end
        if (cmd.op == OP_MUL2)
        begin
            cnt_next = '0;
        end
        else if (cmd.op == OP_DIV)
        begin
            cnt_next = cnt_reg + DIV_CNT_W'(1);
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            have_first_reg <= have_first_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                cur_x_reg    <= in_x;
                cur_y_reg    <= in_y;
                cur_last_reg <= in_last;
            end
            OP_D0:
            begin
                pdist_reg <= smul;
            end
            OP_D1:
            begin
                acc_reg   <= {{2{pdist_reg[DIST_W-1]}}, pdist_reg}
                           - {{2{plane_offset[DIST_W-1]}}, plane_offset};
                pdist_reg <= smul;
            end
            OP_D2:
            begin
                cur_d_reg <= dist_sat;
            end
            OP_XSET:
            begin
                s_reg   <= xs;
                mdx_reg <= xdx[MDX_W-1] ? (~xdx + MDX_W'(1)) : xdx;
                mds_reg <= xds[DIST_W-1] ? (~xds + DIST_W'(1)) : xds;
                den_reg <= xdiff[DIST_W] ? (~xdiff[DIST_W-1:0] + DIST_W'(1))
                                         : xdiff[DIST_W-1:0];
                neg_reg <= (xdx[MDX_W-1] != xds[DIST_W-1]) ^ (xds < xde);
            end
            OP_MUL0:
            begin
                p_reg <= umul;
            end
            OP_MUL1:
            begin
                num_reg <= NUM_W'(p_reg);
                p_reg   <= umul;
            end
            OP_MUL2:
            begin
                num_reg <= num_reg + {p_reg, 32'b0};
                rem_reg <= '0;
                quo_reg <= '0;
                ovf_reg <= 1'b0;
            end
            OP_DIV:
            begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                rem_reg <= div_ge ? (div_try[DIST_W-1:0] - den_reg) : div_try[DIST_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
                ovf_reg <= ovf_reg | quo_reg[QUO_W-1];
            end
            OP_FIN:
            begin
                if (cmd.coord_y)
                begin
                    cy_reg <= fin_val;
                end
                else
                begin
                    cx_reg <= fin_val;
                end
            end
            OP_STORE:
            begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                prev_d_reg <= cur_d_reg;
                if (!have_first_reg)
                begin
                    first_x_reg <= cur_x_reg;
                    first_y_reg <= cur_y_reg;
                    first_d_reg <= cur_d_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            out_x_reg   <= emit_x;
            out_y_reg   <= emit_y;
            out_has_reg <= (cmd.op != OP_EMIT_BARE);
            out_end_reg <= cmd.end_mark;
        end
    end

    assign stat.have_first = have_first_reg;
    assign stat.cur_last   = cur_last_reg;
    assign stat.prev_in    = $signed(prev_d_reg) <= $signed(tol_ext);
    assign stat.cur_in     = $signed(cur_d_reg) <= $signed(tol_ext);
    assign stat.first_in   = $signed(first_d_reg) <= $signed(tol_ext);
    assign stat.div_last   = (cnt_reg == DIV_CNT_W'(NUM_W - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_x          = out_x_reg;
    assign out_y          = out_y_reg;
    assign out_has_vertex = out_has_reg;
    assign out_end        = out_end_reg;

endmodule

>>> rtl/phc_ctrl.sv
// Controller: sequences distance, edge emission, crossing computation and polygon close.
`timescale 1ns / 1ps
module phc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  phc_pkg::dp_stat_t  stat,
    output phc_pkg::dp_cmd_t   cmd
);
    import phc_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_D0      = 15'b000000000000010,
        ST_D1      = 15'b000000000000100,
        ST_D2      = 15'b000000000001000,
        ST_A_START = 15'b000000000010000,
        ST_XSET    = 15'b000000000100000,
        ST_MUL0    = 15'b000000001000000,
        ST_MUL1    = 15'b000000010000000,
        ST_MUL2    = 15'b000000100000000,
        ST_DIV     = 15'b000001000000000,
        ST_FIN     = 15'b000010000000000,
        ST_XEMIT   = 15'b000100000000000,
        ST_STORE   = 15'b001000000000000,
        ST_B_START = 15'b010000000000000,
        ST_BARE    = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   edge_reg, edge_next;
    logic   coord_reg, coord_next;
    logic   any_reg, any_next;
    logic   a_cross, b_cross;

    assign a_cross = stat.prev_in != stat.cur_in;
    assign b_cross = stat.cur_in != stat.first_in;

    always_comb
    begin
        state_next = state_reg;
        edge_next  = edge_reg;
        coord_next = coord_reg;
        any_next   = any_reg;
        cmd.op       = OP_NONE;
        cmd.edge_b   = edge_reg;
        cmd.coord_y  = coord_reg;
        cmd.end_mark = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                any_next = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_D0;
                end
            end
            ST_D0:
            begin
                cmd.op     = OP_D0;
                state_next = ST_D1;
            end
            ST_D1:
            begin
                cmd.op     = OP_D1;
                state_next = ST_D2;
            end
            ST_D2:
            begin
                cmd.op     = OP_D2;
                state_next = ST_A_START;
            end
            ST_A_START:
            begin
                if (!(stat.have_first && stat.prev_in && !stat.out_free))
                begin
                    if (stat.have_first && stat.prev_in)
                    begin
                        cmd.op       = OP_EMIT_START;
                        cmd.edge_b   = 1'b0;
                        cmd.end_mark = stat.cur_last && !a_cross && !stat.cur_in && !b_cross;
                        any_next     = 1'b1;
                    end
                    if (stat.have_first && a_cross)
                    begin
                        edge_next  = 1'b0;
                        coord_next = 1'b0;
                        state_next = ST_XSET;
                    end
                    else
                    begin
                        state_next = ST_STORE;
                    end
                end
            end
            ST_XSET:
            begin
                cmd.op     = OP_XSET;
                state_next = ST_MUL0;
            end
            ST_MUL0:
            begin
                cmd.op     = OP_MUL0;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (stat.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.op = OP_FIN;
                if (!coord_reg)
                begin
                    coord_next = 1'b1;
                    state_next = ST_XSET;
                end
                else
                begin
                    state_next = ST_XEMIT;
                end
            end
            ST_XEMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op       = OP_EMIT_CROSS;
                    cmd.end_mark = edge_reg ? 1'b1
                                 : (stat.cur_last && !stat.cur_in && !b_cross);
                    any_next     = 1'b1;
                    state_next   = edge_reg ? ST_IDLE : ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.op     = OP_STORE;
                state_next = stat.cur_last ? ST_B_START : ST_IDLE;
            end
            ST_B_START:
            begin
                if (!(stat.cur_in && !stat.out_free))
                begin
                    if (stat.cur_in)
                    begin
                        cmd.op       = OP_EMIT_START;
                        cmd.edge_b   = 1'b1;
                        cmd.end_mark = !b_cross;
                        any_next     = 1'b1;
                    end
                    if (b_cross)
                    begin
                        edge_next  = 1'b1;
                        coord_next = 1'b0;
                        state_next = ST_XSET;
                    end
                    else if (any_reg || stat.cur_in)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_BARE;
                    end
                end
            end
            ST_BARE:
            begin
                if (stat.out_free)
                begin
                    cmd.op       = OP_EMIT_BARE;
                    cmd.end_mark = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            edge_reg  <= 1'b0;
            coord_reg <= 1'b0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            coord_reg <= coord_next;
            any_reg   <= any_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

>>> rtl/polygon_half_plane_clipper.sv
// Sequence: a vertex is loaded, its distance is formed in D0, D1 and D2, and its edges are
// emitted; a crossing point adds setup, multiply and the bit-serial 97-step divider, run
// once per coordinate. A new vertex is taken only after the previous one is finished.
// Results wait in an output register; a new vertex is taken while one waits.
// Reset: config to normal 0, offset 0, tolerance 281; awaiting a first vertex, output empty.
`timescale 1ns / 1ps
`include "polygon_half_plane_clipper_assert.svh"
module polygon_half_plane_clipper (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // vertex_x, vertex_y
    input  logic                              s_axis_tlast,  // last_vertex
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [63:0]                       m_axis_tdata,  // out_x, out_y
    output logic                              m_axis_tuser,  // has_vertex
    output logic                              m_axis_tlast,  // end_of_polygon
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [phc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [phc_pkg::CFG_W-1:0]         cfg_data
);
    import phc_pkg::*;

    logic signed [COORD_W-1:0] normal_x_reg, normal_y_reg;
    logic signed [DIST_W-1:0]  plane_offset_reg;
    logic [TOL_W-1:0]          tol_reg;

    dp_cmd_t                   cmd;
    dp_stat_t                  stat;
    logic signed [COORD_W-1:0] out_x, out_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg     <= '0;
            normal_y_reg     <= '0;
            plane_offset_reg <= '0;
            tol_reg          <= TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NORMAL_X:     normal_x_reg     <= cfg_data[COORD_W-1:0];
                CFG_NORMAL_Y:     normal_y_reg     <= cfg_data[COORD_W-1:0];
                CFG_PLANE_OFFSET: plane_offset_reg <= cfg_data[DIST_W-1:0];
                CFG_INSIDE_TOL:   tol_reg          <= cfg_data[TOL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    phc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    phc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_x             (s_axis_tdata[31:0]),
        .in_y             (s_axis_tdata[63:32]),
        .in_last          (s_axis_tlast),
        .normal_x         (normal_x_reg),
        .normal_y         (normal_y_reg),
        .plane_offset     (plane_offset_reg),
        .inside_tolerance (tol_reg),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_x            (out_x),
        .out_y            (out_y),
        .out_has_vertex   (m_axis_tuser),
        .out_end          (m_axis_tlast)
    );

    assign m_axis_tdata = {out_y, out_x};

    `PHC_ASSERT_NEXT(a_one_vertex_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again before previous vertex finished")
    `PHC_ASSERT_NOW(a_bare_marker_ends, m_axis_tvalid && !m_axis_tuser, m_axis_tlast, "bare marker without end of polygon")
    `PHC_ASSERT_NOW(a_bare_marker_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 64'd0, "bare marker carries nonzero coordinates")

endmodule

>>> tb/sv/polygon_half_plane_clipper_tb.sv
// Self-checking testbench for the polygon half-plane clipper: directed and random polygons.
`timescale 1ns / 1ps
module polygon_half_plane_clipper_tb;
    import phc_pkg::*;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam logic signed [127:0] D_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] D_MIN = -D_MAX - 1;
    localparam logic signed [127:0] C_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] C_MIN = -C_MAX - 1;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        has_vertex;
        logic        end_mark;
    } clip_vertex_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    clip_vertex_t clipped_q[$];
    int  errors;
    int  cycles;
    bit  idling_on;

    // predictor copy of registers and polygon state
    int    unsigned       tol_r;
    int    signed         norm_x_r, norm_y_r;
    longint signed        offset_r;
    int    signed         first_x_r, first_y_r, prev_x_r, prev_y_r;
    longint signed        first_d_r, prev_d_r;
    bit                   have_first_r;
    int                   emitted_n;

    polygon_half_plane_clipper uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint signed plane_distance(int signed x, int signed y);
        logic signed [127:0] s;
        s = 128'(longint'(x) * longint'(norm_x_r));
        s = s + 128'(longint'(y) * longint'(norm_y_r));
        s = s - 128'(offset_r);
        if (s > D_MAX)
            return 64'h7FFF_FFFF_FFFF_FFFF;
        if (s < D_MIN)
            return 64'h8000_0000_0000_0000;
        return s[63:0];
    endfunction

    function automatic int signed crossing_at(int signed s, int signed e,
                                              longint signed ds, longint signed de);
        logic signed [127:0] dx, dsw, dew, mden, r;
        logic [127:0] q;
        bit neg;
        dx  = 128'(e) - 128'(s);
        dsw = 128'(ds);
        dew = 128'(de);
        mden = (dsw > dew) ? dsw - dew : dew - dsw;
        neg = (dx < 0) != (dsw < 0);
        if (dsw < dew)
            neg = !neg;
        q = ((dx < 0 ? -dx : dx) * (dsw < 0 ? -dsw : dsw)) / mden;
        if (q > (128'd1 << 40))
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        r = neg ? 128'(s) - $signed(q) : 128'(s) + $signed(q);
        if (r > C_MAX)
            r = C_MAX;
        if (r < C_MIN)
            r = C_MIN;
        return r[31:0];
    endfunction

    task automatic push_clipped(int signed x, int signed y);
        clip_vertex_t v;
        v.x = x;
        v.y = y;
        v.has_vertex = 1'b1;
        v.end_mark = 1'b0;
        clipped_q = {clipped_q, v};
        emitted_n++;
    endtask

    task automatic clip_one_edge(int signed sx, int signed sy, longint signed ds,
                                 int signed ex, int signed ey, longint signed de);
        bit s_in, e_in;
        s_in = ds <= longint'(tol_r);
        e_in = de <= longint'(tol_r);
        if (s_in)
            push_clipped(sx, sy);
        if (s_in != e_in && ds != de)
            push_clipped(crossing_at(sx, ex, ds, de), crossing_at(sy, ey, ds, de));
    endtask

    task automatic predict_vertex(int signed x, int signed y, bit last);
        longint signed d;
        clip_vertex_t v;
        d = plane_distance(x, y);
        emitted_n = 0;
        if (!have_first_r)
        begin
            first_x_r = x; first_y_r = y; first_d_r = d;
            prev_x_r = x; prev_y_r = y; prev_d_r = d;
            have_first_r = 1'b1;
            if (!last)
                return;
            clip_one_edge(x, y, d, x, y, d);
        end
        else
        begin
            clip_one_edge(prev_x_r, prev_y_r, prev_d_r, x, y, d);
            prev_x_r = x; prev_y_r = y; prev_d_r = d;
            if (!last)
                return;
            clip_one_edge(x, y, d, first_x_r, first_y_r, first_d_r);
        end
        have_first_r = 1'b0;
        if (emitted_n == 0)
        begin
            v.x = '0;
            v.y = '0;
            v.has_vertex = 1'b0;
            v.end_mark = 1'b1;
            clipped_q = {clipped_q, v};
        end
        else
            clipped_q[$].end_mark = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
        errors++;
    endtask

    always @(posedge clk)
    begin
        clip_vertex_t v;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("polygon_half_plane_clipper_tb: FAIL");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (clipped_q.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd0, m_axis_tdata[31:0]);
            end
            else
            begin
                v = clipped_q.pop_front();
                if (m_axis_tdata[31:0] !== v.x)
                    report_mismatch("out_x", v.x, m_axis_tdata[31:0]);
                if (m_axis_tdata[63:32] !== v.y)
                    report_mismatch("out_y", v.y, m_axis_tdata[63:32]);
                if (m_axis_tuser !== v.has_vertex)
                    report_mismatch("has_vertex", v.has_vertex, m_axis_tuser);
                if (m_axis_tlast !== v.end_mark)
                    report_mismatch("end_of_polygon", v.end_mark, m_axis_tlast);
            end
        end
        m_axis_tready <= !(idling_on && $urandom_range(99) < 29);
    end

    task automatic send_vertex(int signed x, int signed y, bit last);
        while (idling_on && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_vertex(x, y, last);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (clipped_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NORMAL_X:     norm_x_r = value[31:0];
            CFG_NORMAL_Y:     norm_y_r = value[31:0];
            CFG_PLANE_OFFSET: offset_r = value;
            CFG_INSIDE_TOL:   tol_r    = value[19:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(int signed nx, int signed ny, longint signed off, int unsigned tol);
        drain();
        write_reg(CFG_NORMAL_X, 64'(unsigned'(nx)));
        write_reg(CFG_NORMAL_Y, 64'(unsigned'(ny)));
        write_reg(CFG_PLANE_OFFSET, off);
        write_reg(CFG_INSIDE_TOL, 64'(tol));
    endtask

    // n random vertices, within +-0x0400_0000 of the origin or over the full coordinate range
    task automatic send_polygon(int n, bit full_range);
        int signed x, y;
        for (int i = 0; i < n; i++)
        begin
            if (full_range)
            begin
                x = $urandom;
                y = $urandom;
            end
            else
            begin
                x = $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
                y = $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
            end
            send_vertex(x, y, i == n - 1);
        end
    endtask

    task automatic random_plane();
        int signed nx, ny, cx, cy;
        nx = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        ny = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        cx = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
        cy = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
        set_plane(nx, ny, longint'(nx) * cx + longint'(ny) * cy, $urandom_range(20'hFFFFF));
    endtask

    task automatic test_reset_defaults();
        send_vertex(32'sh0100_0000, -32'sh0100_0000, 1'b0);
        send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_vertex(0, 0, 1'b1);
        send_vertex(-5, 7, 1'b1);
    endtask

    task automatic test_single_and_empty();
        set_plane(32'sh0100_0000, 0, 0, 0);
        send_vertex(-32'sh0100_0000, 3, 1'b1);
        send_vertex(32'sh0100_0000, 3, 1'b1);
        send_vertex(0, 0, 1'b1);
        send_vertex(32'sh0100_0000, 1, 1'b0);
        send_vertex(32'sh0200_0000, 2, 1'b0);
        send_vertex(32'sh0300_0000, 3, 1'b1);
    endtask

    task automatic test_crossings();
        set_plane(32'sh0100_0000, 32'sh0080_0000, 64'sh0000_8000_0000_0000, 281);
        send_vertex(-32'sh0200_0000, -32'sh0100_0000, 1'b0);
        send_vertex(32'sh0300_0000, -32'sh0100_0000, 1'b0);
        send_vertex(32'sh0300_0000, 32'sh0200_0000, 1'b0);
        send_vertex(-32'sh0200_0000, 32'sh0200_0000, 1'b1);
        send_vertex(32'sh0300_0000, 0, 1'b0);
        send_vertex(-32'sh0300_0000, 0, 1'b1);
    endtask

    task automatic test_extremes();
        set_plane(32'sh8000_0000, 32'sh7FFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFFF, 20'hFFFFF);
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
        set_plane(32'sh7FFF_FFFF, 32'sh8000_0000, 64'sh8000_0000_0000_0000, 0);
        send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_vertex(32'sh0000_0001, 32'sh0000_0001, 1'b1);
        set_plane(32'sh0000_0001, 32'sh0000_0001, 0, 0);
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        idling_on = 1'b0;
        while (sent < 106)
        begin
            int n;
            if (sent >= 30)
                idling_on = 1'b1;
            if ($urandom_range(3) == 0)
                random_plane();
            n = ($urandom_range(4) == 0) ? 1 : $urandom_range(7, 2);
            send_polygon(n, $urandom_range(5) == 0);
            sent += n;
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        idling_on = 1'b1;
        tol_r = 281;
        norm_x_r = 0;
        norm_y_r = 0;
        offset_r = 0;
        have_first_r = 1'b0;
        emitted_n = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_NORMAL_X;
        cfg_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_single_and_empty();
        test_crossings();
        test_extremes();
        test_random();
        idling_on = 1'b1;
        drain();
        repeat (500) @(posedge clk);
        if (errors == 0 && clipped_q.size() == 0)
            $display("polygon_half_plane_clipper_tb: PASS");
        else
            $display("polygon_half_plane_clipper_tb: FAIL");
        $finish;
    end
endmodule
